[hdl/mkpq_pkg.sv]
package mkpq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam int OCC_W = 5;

  // One queued request, id in the lowest bits
  typedef struct packed {
    logic [15:0] order;
    logic [15:0] service;
    logic [15:0] arrival;
    logic [7:0]  prio;
    logic [15:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
  // entry, occupancy, zero fill up to whole bytes
  localparam int OUT_W   = ((ENTRY_W + OCC_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_PLACE,
    ST_POP_DATA,
    ST_FINISH
  } state_t;

  // True when a strictly outranks b: higher priority, then earlier arrival,
  // then shorter service, then lower list position.
  function automatic logic outranks(entry_t a, entry_t b);
    return {a.prio, ~a.arrival, ~a.service, ~a.order} >
           {b.prio, ~b.arrival, ~b.service, ~b.order};
  endfunction

endpackage

[hdl/mkpq_ram.sv]
module mkpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/multi_key_priority_queue_unit.sv]
// A pop passes START, POP_DATA, FINISH; a flagged request or an insert into an empty queue
// START, FINISH; other inserts START, SCAN from tail to head, PLACE if passing all, FINISH.
// One beat at a time; the next input beat can be taken once the result is loaded into the
// output register, even while that result still waits at the output.
// The insert walk is set by the single read and single write port of the entry RAM.
// Reset (rst, synchronous): queue empty, output beat dropped; RAM contents are not cleared.
module multi_key_priority_queue_unit import mkpq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // new_id, new_priority, new_arrival, new_service, new_order
  input  logic [ENTRY_W-1:0] s_tdata,
  // cmd
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // head_id, head_priority, head_arrival, head_service, head_order, occupancy, zero fill
  output logic [OUT_W-1:0]   m_tdata,
  // status
  output logic [1:0]         m_tuser
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

  state_t state, state_next;

  // Latched command and request
  logic    cur_cmd;
  entry_t  cur_entry;

  // Circular buffer: logical slot 0 (the head) sits at physical address head.
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [AW-1:0] scan_idx;

  logic [1:0] res_status;
  entry_t     res_entry;

  // RAM access in logical slot numbers
  logic          ram_we, ram_re;
  logic [AW-1:0] wr_log, rd_log;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW:0]   wr_sum, rd_sum;
  entry_t        wr_data, rd_data;

  logic full, empty, is_outrank, out_free;

  assign full       = (count == DEPTH_C);
  assign empty      = (count == '0);
  assign is_outrank = outranks(cur_entry, rd_data);
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE);

  // Map logical slot to physical address, wrap once past the depth
  always_comb begin
    wr_sum  = (AW+1)'(head) + (AW+1)'(wr_log);
    rd_sum  = (AW+1)'(head) + (AW+1)'(rd_log);
    wr_addr = (wr_sum >= DEPTH_A) ? AW'(wr_sum - DEPTH_A) : AW'(wr_sum);
    rd_addr = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : AW'(rd_sum);
  end

  // The insert walks from the tail toward the head: it reads slot j-1 while
  // writing slot j+1, so a read never meets the write of the same entry.
  mkpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_START;
      end
      ST_START: begin
        if (cur_cmd == CMD_INSERT) begin
          if (full || empty) state_next = ST_FINISH;
          else               state_next = ST_SCAN;
        end else begin
          if (empty) state_next = ST_FINISH;
          else       state_next = ST_POP_DATA;
        end
      end
      ST_SCAN: begin
        if (!is_outrank)          state_next = ST_FINISH;
        else if (scan_idx == '0)  state_next = ST_PLACE;
      end
      ST_PLACE:    state_next = ST_FINISH;
      ST_POP_DATA: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    wr_log  = '0;
    rd_log  = '0;
    wr_data = cur_entry;
    case (state)
      ST_START: begin
        if (cur_cmd == CMD_INSERT) begin
          if (!full && empty) begin
            ram_we = 1'b1;
          end else if (!full) begin
            ram_re = 1'b1;
            rd_log = AW'(count - 1'b1);
          end
        end else if (!empty) begin
          ram_re = 1'b1;
        end
      end
      ST_SCAN: begin
        ram_we = 1'b1;
        wr_log = scan_idx + 1'b1;
        if (is_outrank) begin
          // shift the passed request back by one slot
          wr_data = rd_data;
          if (scan_idx != '0) begin
            ram_re = 1'b1;
            rd_log = scan_idx - 1'b1;
          end
        end
      end
      ST_PLACE: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur_cmd   <= s_tuser;
            cur_entry <= s_tdata;
          end
        end
        ST_START: begin
          res_entry <= '0;
          if (cur_cmd == CMD_INSERT) begin
            if (full) begin
              res_status <= STATUS_FULL;
            end else begin
              res_status <= STATUS_OK;
              if (empty) begin
                count <= count + 1'b1;
              end else begin
                scan_idx <= AW'(count - 1'b1);
              end
            end
          end else if (empty) begin
            res_status <= STATUS_EMPTY;
          end else begin
            res_status <= STATUS_OK;
          end
        end
        ST_SCAN: begin
          if (!is_outrank) begin
            count <= count + 1'b1;
          end else if (scan_idx != '0) begin
            scan_idx <= scan_idx - 1'b1;
          end
        end
        ST_PLACE: begin
          count <= count + 1'b1;
        end
        ST_POP_DATA: begin
          // drop the head by advancing the pointer
          res_entry <= rd_data;
          head      <= (head == LAST_A) ? '0 : head + 1'b1;
          count     <= count - 1'b1;
        end
        default: ;
      endcase

      // Output register: load when free, drop the beat once taken
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {(OUT_W - ENTRY_W - OCC_W)'(0), OCC_W'(count), res_entry};
        m_tuser  <= res_status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[hdl/mkpq_checker.sv]
module mkpq_checker import mkpq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [OUT_W-1:0]   m_tdata,
  input logic [1:0]         m_tuser
);

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // One request at a time: drop ready right after a taken beat
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready stayed high after a taken beat");

  // Flagged results carry no request
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STATUS_OK |-> m_tdata[ENTRY_W-1:0] == '0)
    else $error("flagged result carries request fields");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_FULL |-> m_tdata[ENTRY_W+OCC_W-1:ENTRY_W] == FULL_OCC)
    else $error("full flag with queue not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_EMPTY |-> m_tdata[ENTRY_W+OCC_W-1:ENTRY_W] == '0)
    else $error("empty flag with queue not empty");

endmodule

bind multi_key_priority_queue_unit mkpq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mkpq_checker (.*);

[bench/tb_multi_key_priority_queue_unit.sv]
module tb_multi_key_priority_queue_unit;
  import mkpq_pkg::*;

  localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT;
  localparam int PLAN_ROWS    = 25;
  localparam int RANDOM_ITEMS = 1025;
  localparam int IDLE_PCT     = 36;
  // Leave room past the longest insert walk for output stalls.
  localparam int TAIL_CYCLES  = 3 * (QUEUE_DEPTH + 5);
  localparam int QUIET_LIMIT  = 4000;

  typedef struct {
    logic [1:0]       status;
    entry_t           head;
    logic [OCC_W-1:0] occ;
  } outcome_t;

  typedef struct {
    logic     cmd;
    entry_t   req;
    bit       typed;   // use the hand-written outcome instead of the shadow queue
    outcome_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [ENTRY_W-1:0] s_tdata = '0;
  logic               s_tuser = CMD_INSERT;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic [1:0]         m_tuser;

  // Shadow of the queue contents, head at slot 0.
  entry_t    shadow_slot [QUEUE_DEPTH];
  int        shadow_held;
  outcome_t  pending_outcomes [$];
  outcome_t  oldest;
  plan_row_t plan [PLAN_ROWS];
  int        beats_in;
  int        beats_out;
  int        mismatches;
  int        quiet_cycles;
  bit        calm;       // no idling on either side while set
  bit        filling;

  multi_key_priority_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  function automatic entry_t ent(logic [15:0] id, logic [7:0] prio, logic [15:0] arrival,
                                 logic [15:0] service, logic [15:0] order);
    entry_t e;
    e.id      = id;
    e.prio    = prio;
    e.arrival = arrival;
    e.service = service;
    e.order   = order;
    return e;
  endfunction

  function automatic plan_row_t row(logic cmd, entry_t req, bit typed, logic [1:0] status,
                                    entry_t head, int occ);
    plan_row_t r;
    r.cmd         = cmd;
    r.req         = req;
    r.typed       = typed;
    r.want.status = status;
    r.want.head   = head;
    r.want.occ    = occ[OCC_W-1:0];
    return r;
  endfunction

  // Key order: priority high first, then arrival, service and list position low first.
  function automatic bit ranks_ahead(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    if (a.arrival != b.arrival) return a.arrival < b.arrival;
    if (a.service != b.service) return a.service < b.service;
    return a.order < b.order;
  endfunction

  // Advance the shadow queue by one accepted request and return its outcome.
  function automatic outcome_t apply_request(logic cmd, entry_t req);
    outcome_t r;
    int       pos;
    r.status = STATUS_OK;
    r.head   = '0;
    if (cmd == CMD_INSERT) begin
      if (shadow_held >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // Slot in front of the first entry the new key strictly beats;
        // equal keys therefore land behind their twins.
        pos = shadow_held;
        for (int i = shadow_held - 1; i >= 0; i--)
          if (ranks_ahead(req, shadow_slot[i])) pos = i;
        for (int i = shadow_held; i > pos; i--) shadow_slot[i] = shadow_slot[i-1];
        shadow_slot[pos] = req;
        shadow_held++;
      end
    end else if (shadow_held == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.head = shadow_slot[0];
      for (int i = 1; i < shadow_held; i++) shadow_slot[i-1] = shadow_slot[i];
      shadow_held--;
    end
    r.occ = shadow_held[OCC_W-1:0];
    return r;
  endfunction

  // Narrow values half the time so that ties reach every level of the key.
  function automatic logic [15:0] key_field();
    case ($urandom_range(3))
      0: return 16'($urandom_range(3));
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    $display("[%0t] result beat %0d: %s", $realtime, beats_out, what);
    mismatches++;
  endtask

  // Present one beat after an optional random gap; return at the accepting edge.
  task automatic send_request(input logic cmd, input entry_t req, input bit typed,
                              input outcome_t want);
    outcome_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = req;
    do @(posedge clk); while (!s_tready);
    predicted = apply_request(cmd, req);
    pending_outcomes.push_back(typed ? want : predicted);
    beats_in++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Output side: stall at random except during the calm stretch.
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result beat against the oldest outstanding outcome.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        note_mismatch("result beat with nothing outstanding");
      end else begin
        oldest = pending_outcomes.pop_front();
        if (m_tuser !== oldest.status)
          note_mismatch($sformatf("status %0d, want %0d", m_tuser, oldest.status));
        if (m_tdata[15:0] !== oldest.head.id)
          note_mismatch($sformatf("head_id %h, want %h", m_tdata[15:0], oldest.head.id));
        if (m_tdata[23:16] !== oldest.head.prio)
          note_mismatch($sformatf("head_priority %h, want %h", m_tdata[23:16],
                                  oldest.head.prio));
        if (m_tdata[39:24] !== oldest.head.arrival)
          note_mismatch($sformatf("head_arrival %h, want %h", m_tdata[39:24],
                                  oldest.head.arrival));
        if (m_tdata[55:40] !== oldest.head.service)
          note_mismatch($sformatf("head_service %h, want %h", m_tdata[55:40],
                                  oldest.head.service));
        if (m_tdata[71:56] !== oldest.head.order)
          note_mismatch($sformatf("head_order %h, want %h", m_tdata[71:56],
                                  oldest.head.order));
        if (m_tdata[ENTRY_W +: OCC_W] !== oldest.occ)
          note_mismatch($sformatf("occupancy %0d, want %0d", m_tdata[ENTRY_W +: OCC_W],
                                  oldest.occ));
      end
      beats_out++;
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
      $display("tb_multi_key_priority_queue_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    entry_t    none;
    entry_t    top;
    entry_t    req;
    logic      cmd;
    outcome_t  unused;

    none          = '0;
    top           = ent(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    unused        = '{default: '0};
    shadow_held   = 0;
    beats_in      = 0;
    calm          = 1'b0;
    filling       = 1'b1;

    // Empty pops, extreme keys, then a fill with ties at every key level,
    // an insert into the full queue and a couple of pops.
    plan[0]  = row(CMD_POP,    none, 1, STATUS_EMPTY, none, 0);
    plan[1]  = row(CMD_INSERT, top,  1, STATUS_OK,    none, 1);
    plan[2]  = row(CMD_INSERT, none, 1, STATUS_OK,    none, 2);
    plan[3]  = row(CMD_POP,    none, 1, STATUS_OK,    top,  1);
    plan[4]  = row(CMD_POP,    none, 1, STATUS_OK,    none, 0);
    plan[5]  = row(CMD_POP,    none, 1, STATUS_EMPTY, none, 0);
    plan[6]  = row(CMD_INSERT, ent(16'h0001, 8'd80, 16'd100, 16'd50, 16'd7), 0, 0, none, 0);
    plan[7]  = row(CMD_INSERT, ent(16'h0002, 8'd80, 16'd100, 16'd50, 16'd7), 0, 0, none, 0);
    plan[8]  = row(CMD_INSERT, ent(16'h0003, 8'd80, 16'd100, 16'd50, 16'd6), 0, 0, none, 0);
    plan[9]  = row(CMD_INSERT, ent(16'h0004, 8'd80, 16'd100, 16'd49, 16'd9), 0, 0, none, 0);
    plan[10] = row(CMD_INSERT, ent(16'h0005, 8'd80, 16'd99,  16'd60, 16'd9), 0, 0, none, 0);
    plan[11] = row(CMD_INSERT, ent(16'h0006, 8'd81, 16'd200, 16'd60, 16'd9), 0, 0, none, 0);
    plan[12] = row(CMD_INSERT, ent(16'h0007, 8'd79, 16'd0,   16'd0,  16'd0), 0, 0, none, 0);
    plan[13] = row(CMD_INSERT, ent(16'h0008, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, 0,
                   none, 0);
    plan[14] = row(CMD_INSERT, ent(16'h0009, 8'h00, 16'h0000, 16'h0000, 16'h0000), 0, 0,
                   none, 0);
    plan[15] = row(CMD_INSERT, ent(16'h000A, 8'd80, 16'd100, 16'd50, 16'd8), 0, 0, none, 0);
    plan[16] = row(CMD_INSERT, ent(16'hAAAA, 8'h55, 16'h5555, 16'hAAAA, 16'h5555), 0, 0,
                   none, 0);
    plan[17] = row(CMD_INSERT, ent(16'h5555, 8'hAA, 16'hAAAA, 16'h5555, 16'hAAAA), 0, 0,
                   none, 0);
    plan[18] = row(CMD_INSERT, ent(16'h8000, 8'h80, 16'h8000, 16'h8000, 16'h8000), 0, 0,
                   none, 0);
    plan[19] = row(CMD_INSERT, ent(16'h7FFF, 8'h7F, 16'h7FFF, 16'h7FFF, 16'h7FFF), 0, 0,
                   none, 0);
    plan[20] = row(CMD_INSERT, ent(16'h1234, 8'd80, 16'd100, 16'd50, 16'd7), 0, 0, none, 0);
    plan[21] = row(CMD_INSERT, ent(16'hFFFE, 8'h00, 16'h0000, 16'h0000, 16'h0000), 0, 0,
                   none, 0);
    plan[22] = row(CMD_INSERT, ent(16'hDEAD, 8'hFF, 16'h0000, 16'h0000, 16'h0000), 1,
                   STATUS_FULL, none, QUEUE_DEPTH);
    plan[23] = row(CMD_POP,    none, 0, 0, none, 0);
    plan[24] = row(CMD_POP,    none, 0, 0, none, 0);

    // Hold reset, then release it on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) send_request(plan[i].cmd, plan[i].req, plan[i].typed, plan[i].want);
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 400 && n < 600);
      // Sweep the queue between empty and full, lingering at each end for a while
      // so that full inserts and empty pops keep turning up.
      if (shadow_held == QUEUE_DEPTH && filling && $urandom_range(2) == 0) filling = 1'b0;
      if (shadow_held == 0 && !filling && $urandom_range(2) == 0) filling = 1'b1;
      cmd = ($urandom_range(99) < (filling ? 70 : 30)) ? CMD_INSERT : CMD_POP;
      req = ent(16'($urandom), 8'(key_field()), key_field(), key_field(), key_field());
      // Pops carry random payload too; the block must ignore it.
      send_request(cmd, req, 0, unused);
      if (n % 250 == 249) hold_until_drained();
    end

    calm = 1'b0;
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_multi_key_priority_queue_unit: PASS");
    end else begin
      $display("tb_multi_key_priority_queue_unit: FAIL");
    end
    $finish;
  end

endmodule

[multi_key_priority_queue_unit.f]
hdl/mkpq_pkg.sv
hdl/mkpq_ram.sv
hdl/multi_key_priority_queue_unit.sv
hdl/mkpq_checker.sv
bench/tb_multi_key_priority_queue_unit.sv
